// File: hw/rtl/color_frequency_histogram_core_macros.svh
// Assertion macros shared by the color histogram RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef COLOR_FREQUENCY_HISTOGRAM_CORE_MACROS_SVH
`define COLOR_FREQUENCY_HISTOGRAM_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFH_ASSERT_SAME(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("color histogram assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFH_ASSERT_NEXT(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("color histogram assertion failed");

`endif

// File: hw/rtl/cfh_pkg.sv
// Shared types and constants for the color frequency histogram core.
// Depends on nothing; the core RTL and the testbench import it.
package cfh_pkg;

    localparam int NUM_COLORS_DEFAULT = 1024;
    localparam int WINDOW_MAX_DEFAULT = 1024;

    localparam int COLOR_W = 10;
    localparam int THRESHOLD_W = 11;
    localparam int TOTAL_W = 11;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'd2047;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_REMOVE_AT_ZERO = 2'd1;
    localparam logic [1:0] ST_ADD_AT_MAX = 2'd2;

    typedef struct packed {
        logic [1:0]             op;
        logic [COLOR_W-1:0]     color;
        logic [THRESHOLD_W-1:0] threshold;
    } item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] color_total;
        logic [1:0]         status;
    } result_t;

endpackage

// File: hw/rtl/color_frequency_histogram_core.sv
// Color frequency histogram core: per-color counts and a histogram of those counts.
// Depends on cfh_pkg, cfh_ram and color_frequency_histogram_core_macros.svh.
//
// After reset the core zeroes every entry of its two RAMs and holds item_stall high
// meanwhile. It then works on one beat at a time. An add or remove makes one read of
// the count RAM and two read-modify-write passes over the histogram RAM. An add at the
// maximum or a remove at zero is dropped after the count read, and an unused op goes
// straight to its result. A query walks the histogram RAM one bin per cycle from
// max(threshold, 1) up to WINDOW_MAX; a threshold above WINDOW_MAX reads no bin. A
// finished result waits in an output register, which the core refills only once the
// previous result beat has been taken.
module color_frequency_histogram_core #(
    parameter int NUM_COLORS = cfh_pkg::NUM_COLORS_DEFAULT,
    parameter int WINDOW_MAX = cfh_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  cfh_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output cfh_pkg::result_t result
);

    import cfh_pkg::*;
    `include "color_frequency_histogram_core_macros.svh"

    localparam int CAW = $clog2(NUM_COLORS);
    localparam int HDEPTH = WINDOW_MAX + 1;
    localparam int HAW = $clog2(HDEPTH);
    localparam int HW = $clog2(NUM_COLORS + 1);
    localparam int PW = $clog2(WINDOW_MAX + 2);
    localparam int CLR_N = (NUM_COLORS > HDEPTH) ? NUM_COLORS : HDEPTH;
    localparam int CLRW = $clog2(CLR_N);
    localparam int SW = ((HW > TOTAL_W) ? HW : TOTAL_W) + 1;

    localparam logic [2:0] S_CLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CNT = 3'd2;
    localparam logic [2:0] S_H1 = 3'd3;
    localparam logic [2:0] S_H2 = 3'd4;
    localparam logic [2:0] S_QRY = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [CLRW-1:0]    clr_ptr_reg, clr_ptr_next;
    logic [1:0]         op_reg, op_next;
    logic [CAW-1:0]     color_reg, color_next;
    logic [HAW-1:0]     n_reg, n_next;
    logic [HAW-1:0]     n_new_reg, n_new_next;
    logic [PW-1:0]      ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next;
    logic [1:0]         status_reg, status_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;

    logic               cnt_we;
    logic [CAW-1:0]     cnt_waddr;
    logic [HAW-1:0]     cnt_wdata;
    logic [CAW-1:0]     cnt_raddr;
    logic [HAW-1:0]     cnt_rdata;
    logic               hist_we;
    logic [HAW-1:0]     hist_waddr;
    logic [HW-1:0]      hist_wdata;
    logic [HAW-1:0]     hist_raddr;
    logic [HW-1:0]      hist_rdata;

    logic [31:0]            color_ext;
    logic                   color_ok;
    logic [THRESHOLD_W-1:0] k;
    logic                   issue_ok;
    logic [SW-1:0]          sum_wide;
    logic [TOTAL_W-1:0]     sum_acc;
    logic                   out_free;

    cfh_ram #(
        .WIDTH (HAW),
        .DEPTH (NUM_COLORS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    cfh_ram #(
        .WIDTH (HW),
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign color_ext = 32'(item.color);
    assign color_ok = color_ext < 32'(NUM_COLORS);
    assign k = (item.threshold == '0) ? THRESHOLD_W'(1) : item.threshold;
    assign issue_ok = 32'(ptr_reg) <= 32'(WINDOW_MAX);
    assign sum_wide = SW'(sum_reg) + SW'(hist_rdata);
    assign sum_acc = (sum_wide > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
    assign out_free = !result_valid_reg || !result_stall;

    assign item_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_ptr_next = clr_ptr_reg;
        op_next = op_reg;
        color_next = color_reg;
        n_next = n_reg;
        n_new_next = n_new_reg;
        ptr_next = ptr_reg;
        pend_next = pend_reg;
        sum_next = sum_reg;
        status_next = status_reg;
        result_next = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        cnt_we = 1'b0;
        cnt_waddr = color_reg;
        cnt_wdata = '0;
        cnt_raddr = color_ext[CAW-1:0];
        hist_we = 1'b0;
        hist_waddr = n_reg;
        hist_wdata = '0;
        hist_raddr = '0;

        case (state_reg)
            S_CLR:
            begin
                cnt_we = 32'(clr_ptr_reg) < 32'(NUM_COLORS);
                cnt_waddr = clr_ptr_reg[CAW-1:0];
                hist_we = 32'(clr_ptr_reg) < 32'(HDEPTH);
                hist_waddr = clr_ptr_reg[HAW-1:0];
                clr_ptr_next = clr_ptr_reg + CLRW'(1);
                if (32'(clr_ptr_reg) == 32'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next = item.op;
                    color_next = color_ext[CAW-1:0];
                    sum_next = '0;
                    status_next = ST_OK;
                    pend_next = 1'b0;
                    case (item.op)
                        OP_ADD, OP_REMOVE:
                        begin
                            state_next = color_ok ? S_CNT : S_DONE;
                        end
                        OP_QUERY:
                        begin
                            if (32'(k) <= 32'(WINDOW_MAX))
                            begin
                                ptr_next = PW'(k);
                                state_next = S_QRY;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CNT:
            begin
                n_next = cnt_rdata;
                hist_raddr = cnt_rdata;
                if (op_reg == OP_ADD)
                begin
                    n_new_next = cnt_rdata + HAW'(1);
                    if (32'(cnt_rdata) >= 32'(WINDOW_MAX))
                    begin
                        status_next = ST_ADD_AT_MAX;
                    end
                end
                else
                begin
                    n_new_next = cnt_rdata - HAW'(1);
                    if (cnt_rdata == '0)
                    begin
                        status_next = ST_REMOVE_AT_ZERO;
                    end
                end
                if (status_next == ST_OK)
                begin
                    cnt_we = 1'b1;
                    cnt_wdata = n_new_next;
                    state_next = S_H1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_H1:
            begin
                hist_we = (n_reg != '0);
                hist_waddr = n_reg;
                hist_wdata = hist_rdata - HW'(1);
                hist_raddr = n_new_reg;
                state_next = S_H2;
            end
            S_H2:
            begin
                hist_we = (n_new_reg != '0);
                hist_waddr = n_new_reg;
                hist_wdata = hist_rdata + HW'(1);
                state_next = S_DONE;
            end
            S_QRY:
            begin
                hist_raddr = ptr_reg[HAW-1:0];
                if (pend_reg)
                begin
                    sum_next = sum_acc;
                end
                if (issue_ok)
                begin
                    ptr_next = ptr_reg + PW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    result_next.color_total = sum_reg;
                    result_next.status = status_reg;
                    result_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_ptr_reg <= '0;
            pend_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            pend_reg <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        color_reg <= color_next;
        n_reg <= n_next;
        n_new_reg <= n_new_next;
        ptr_reg <= ptr_next;
        sum_reg <= sum_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    `CFH_ASSERT_SAME(a_no_result_in_clear, state_reg == S_CLR, !result_valid_reg)
    `CFH_ASSERT_SAME(a_bin_zero_untouched, hist_we && state_reg != S_CLR, hist_waddr != '0)
    `CFH_ASSERT_SAME(a_count_write_phase, cnt_we, state_reg == S_CNT || state_reg == S_CLR)
    `CFH_ASSERT_NEXT(a_done_delivers, state_reg == S_DONE && out_free,
                     result_valid_reg && state_reg == S_IDLE)

endmodule

// File: hw/rtl/cfh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for both stores of the histogram core.
module cfh_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: bench/tb_color_frequency_histogram_core.sv
// Testbench for color_frequency_histogram_core: drives add, remove, query and unused-op
// beats and checks every result beat against an in-bench count and histogram predictor.
// Depends on cfh_pkg and the core RTL only.
module tb_color_frequency_histogram_core;
    import cfh_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOT_COLORS = 12;
    localparam int FILL_ADDS = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item_beat = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result_beat;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fault_count = 0;
    int quiet_cycles = 0;

    item_t item_backlog[$];
    result_t due_results[$];

    int unsigned color_tally [NUM_COLORS_DEFAULT] = '{default: 0};
    int unsigned tally_bins [WINDOW_MAX_DEFAULT + 1] = '{default: 0};
    logic [COLOR_W-1:0] hot_set [HOT_COLORS];

    color_frequency_histogram_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat)
    );

    always #5 clk = ~clk;

    function automatic result_t apply_histogram_op(item_t it);
        result_t r;
        int unsigned n;
        int unsigned sum;
        int unsigned lo;
        r = '0;
        r.status = ST_OK;
        case (it.op)
            OP_ADD:
            begin
                n = color_tally[it.color];
                if (n >= WINDOW_MAX_DEFAULT)
                begin
                    r.status = ST_ADD_AT_MAX;
                end
                else
                begin
                    if (n > 0)
                    begin
                        tally_bins[n] = tally_bins[n] - 1;
                    end
                    color_tally[it.color] = n + 1;
                    tally_bins[n + 1] = tally_bins[n + 1] + 1;
                end
            end
            OP_REMOVE:
            begin
                n = color_tally[it.color];
                if (n == 0)
                begin
                    r.status = ST_REMOVE_AT_ZERO;
                end
                else
                begin
                    tally_bins[n] = tally_bins[n] - 1;
                    color_tally[it.color] = n - 1;
                    if (n > 1)
                    begin
                        tally_bins[n - 1] = tally_bins[n - 1] + 1;
                    end
                end
            end
            OP_QUERY:
            begin
                sum = 0;
                lo = (it.threshold == 0) ? 1 : it.threshold;
                for (int unsigned f = lo; f <= WINDOW_MAX_DEFAULT; f++)
                begin
                    sum = sum + tally_bins[f];
                    if (sum > TOTAL_MAX)
                    begin
                        sum = TOTAL_MAX;
                    end
                end
                r.color_total = sum[TOTAL_W-1:0];
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic item_t make_random_item();
        item_t it;
        int unsigned pick;
        it.color = COLOR_W'($urandom_range(0, NUM_COLORS_DEFAULT - 1));
        if ($urandom_range(99) < 70)
        begin
            it.color = hot_set[$urandom_range(HOT_COLORS - 1)];
        end
        pick = $urandom_range(99);
        if (pick < 42)
        begin
            it.op = OP_ADD;
        end
        else if (pick < 65)
        begin
            it.op = OP_REMOVE;
        end
        else if (pick < 95)
        begin
            it.op = OP_QUERY;
        end
        else
        begin
            it.op = OP_UNUSED;
        end
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            it.threshold = THRESHOLD_W'($urandom_range(0, 12));
        end
        else if (pick < 65)
        begin
            it.threshold = THRESHOLD_W'($urandom_range(0, WINDOW_MAX_DEFAULT));
        end
        else if (pick < 85)
        begin
            it.threshold = THRESHOLD_W'($urandom_range(WINDOW_MAX_DEFAULT, 2047));
        end
        else
        begin
            it.threshold = THRESHOLD_W'($urandom);
        end
        return it;
    endfunction

    task automatic queue_item(logic [1:0] op, int unsigned color, int unsigned threshold);
        item_t it;
        it.op = op;
        it.color = COLOR_W'(color);
        it.threshold = THRESHOLD_W'(threshold);
        item_backlog.insert(item_backlog.size(), it);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
        begin
            item_backlog.insert(item_backlog.size(), make_random_item());
        end
    endtask

    task automatic drain_backlog();
        while (item_backlog.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Driver: a beat is predicted at the edge where it is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                due_results.insert(due_results.size(), apply_histogram_op(item_beat));
            end
            if (!item_valid || !item_stall)
            begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_beat <= item_backlog.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                    begin
                        $display("unexpected result beat: total %0d status %0d",
                                 result_beat.color_total, result_beat.status);
                    end
                    fault_count <= fault_count + 1;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_beat.color_total !== want.color_total
                        || result_beat.status !== want.status)
                    begin
                        if (fault_count < REPORT_LIMIT)
                        begin
                            $display("mismatch: expected total %0d status %0d, got %0d %0d",
                                     want.color_total, want.status,
                                     result_beat.color_total, result_beat.status);
                        end
                        fault_count <= fault_count + 1;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int unsigned fill_color;
        for (int i = 0; i < HOT_COLORS; i++)
        begin
            hot_set[i] = COLOR_W'($urandom_range(0, NUM_COLORS_DEFAULT - 1));
        end
        fill_color = $urandom_range(1, NUM_COLORS_DEFAULT - 2);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct <= 7;
        recv_stall_pct <= 86;

        queue_item(OP_QUERY, 0, 0);
        queue_item(OP_REMOVE, 0, 2047);
        queue_item(OP_ADD, 0, 0);
        queue_item(OP_ADD, NUM_COLORS_DEFAULT - 1, 2047);
        queue_item(OP_QUERY, NUM_COLORS_DEFAULT - 1, 0);
        queue_item(OP_QUERY, 0, 1);
        queue_item(OP_QUERY, 0, WINDOW_MAX_DEFAULT);
        queue_item(OP_QUERY, 0, WINDOW_MAX_DEFAULT + 1);
        queue_item(OP_QUERY, NUM_COLORS_DEFAULT - 1, 2047);
        queue_item(OP_REMOVE, NUM_COLORS_DEFAULT - 1, 0);
        queue_item(OP_REMOVE, NUM_COLORS_DEFAULT - 1, 0);
        queue_item(OP_UNUSED, 0, 0);
        queue_item(OP_UNUSED, NUM_COLORS_DEFAULT - 1, 2047);
        queue_item(OP_ADD, 5, 0);
        queue_item(OP_ADD, 5, 0);
        queue_item(OP_ADD, 5, 0);
        queue_item(OP_QUERY, 0, 3);
        queue_item(OP_QUERY, 0, 2);
        queue_item(OP_QUERY, 0, 4);

        // Push one color to a high count so that deep histogram bins are exercised.
        for (int i = 0; i < FILL_ADDS; i++)
        begin
            queue_item(OP_ADD, fill_color, $urandom_range(0, 2047));
        end
        queue_item(OP_QUERY, 0, FILL_ADDS);
        queue_item(OP_QUERY, 0, FILL_ADDS - 1);
        queue_item(OP_REMOVE, fill_color, 0);
        queue_item(OP_QUERY, 0, FILL_ADDS);
        queue_item(OP_ADD, fill_color, 0);
        queue_item(OP_ADD, fill_color, 0);
        queue_item(OP_QUERY, 0, 0);

        queue_random(165);
        drain_backlog();
        send_idle_pct <= 86;
        recv_stall_pct <= 7;
        queue_random(165);
        drain_backlog();
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
        queue_random(160);
        drain_backlog();

        while (item_valid || due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/cfh_pkg.sv
hw/rtl/cfh_ram.sv
hw/rtl/color_frequency_histogram_core.sv
bench/tb_color_frequency_histogram_core.sv
